FILE: hdl/crash_loop_circuit_breaker_core_macros.svh
// ----------------------------------------------------------------------------
// Crash-loop breaker assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef CRASH_LOOP_CIRCUIT_BREAKER_CORE_MACROS_SVH
`define CRASH_LOOP_CIRCUIT_BREAKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every edge outside reset
`define CLCB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition at one edge implies another at the next edge
`define CLCB_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) \
        else $error(msg);

`else

`define CLCB_ASSERT(name, prop, msg)
`define CLCB_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

FILE: hdl/clcb_pkg.sv
// ----------------------------------------------------------------------------
// Crash-loop breaker package
// Codes, widths, reset values and controller/datapath interface types.
// ----------------------------------------------------------------------------
package clcb_pkg;

    // default number of stored crash times
    localparam int CLCB_DEPTH = 16;

    // field widths
    localparam int MODE_W     = 2;
    localparam int TIME_W     = 32;
    localparam int ACTION_W   = 2;
    localparam int KIND_W     = 3;
    localparam int BACKOFF_W  = 12;
    localparam int CONSEC_W   = 8;
    localparam int WINDOW_W   = 16;
    localparam int RETRY_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // backoff doubling stops after this many steps
    localparam int BACKOFF_SHIFT_CAP = 6;
    localparam int SHIFTED_W         = BACKOFF_W + BACKOFF_SHIFT_CAP;

    localparam logic [CONSEC_W-1:0] CONSEC_MAX = 8'd255;

    // event codes
    localparam logic [MODE_W-1:0] MODE_LAUNCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESPAWN = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TRIP    = 2'd3;

    // incident codes
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAIN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SAFE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROLLBACK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRIP     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_INIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX  = 2'd3;

    // configuration reset values
    localparam logic [WINDOW_W-1:0]  RST_WINDOW       = 16'd60;
    localparam logic [RETRY_W-1:0]   RST_MAX_RETRIES  = 5'd5;
    localparam logic [BACKOFF_W-1:0] RST_BACKOFF_INIT = 12'd1;
    localparam logic [BACKOFF_W-1:0] RST_BACKOFF_MAX  = 12'd60;

    // controller to datapath
    typedef struct packed {
        logic load;     // take the input item, set up the prune walk
        logic scan;     // one step of the prune walk
        logic update;   // apply the event to the state
        logic emit;     // load the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_crash;   // offered item is an unclean exit
        logic scan_done;  // prune walk finished
        logic out_free;   // result register can take a new item
    } t_dp_sts;

endpackage

FILE: hdl/clcb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/clcb_ctrl.sv
// ----------------------------------------------------------------------------
// Crash-loop breaker controller
// Sequences accept, prune walk, state update and result hand-off.
// ----------------------------------------------------------------------------
module clcb_ctrl
    import clcb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PRUNE  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_crash ? S_PRUNE : S_UPDATE;
                end
            end
            S_PRUNE: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hdl/clcb_dpath.sv
// ----------------------------------------------------------------------------
// Crash-loop breaker datapath
// Config registers, breaker state, crash time store with prune walk, and
// the result register.
// ----------------------------------------------------------------------------
module clcb_dpath
    import clcb_pkg::*;
#(
    parameter int DEPTH = CLCB_DEPTH,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_now_sec,
    input  logic                  i_exit_clean,
    input  logic                  i_rollback_ready,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [ACTION_W-1:0]   o_action,
    output logic [KIND_W-1:0]     o_incident_kind,
    output logic [BACKOFF_W-1:0]  o_backoff_sec,
    output logic [CW-1:0]         o_crashes_in_window,
    output logic [CONSEC_W-1:0]   o_consecutive_crashes,
    output logic                  o_safe_mode_on,
    output logic                  o_rollback_on
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = (CW > RETRY_W) ? CW : RETRY_W;
    localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // configuration
    logic [WINDOW_W-1:0]  r_window;
    logic [RETRY_W-1:0]   r_max_retries;
    logic [BACKOFF_W-1:0] r_binit;
    logic [BACKOFF_W-1:0] r_bmax;

    // breaker state
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_oldest;
    logic [CONSEC_W-1:0] r_consec;
    logic                r_safe;
    logic                r_rb;
    logic [TIME_W-1:0]   r_launch;

    // latched item
    logic [MODE_W-1:0] r_mode;
    logic [TIME_W-1:0] r_now;
    logic              r_clean;
    logic              r_ready;

    // prune walk
    logic [CW-1:0] r_rd_idx;
    logic [IW-1:0] r_rd_slot;
    logic [IW-1:0] r_wr_slot;
    logic [CW-1:0] r_kept;
    logic          r_pend;

    // event outcome
    logic [ACTION_W-1:0] r_action;
    logic [KIND_W-1:0]   r_kind;

    // result register
    logic                 r_out_valid;
    logic [ACTION_W-1:0]  r_o_action;
    logic [KIND_W-1:0]    r_o_kind;
    logic [BACKOFF_W-1:0] r_o_backoff;
    logic [CW-1:0]        r_o_count;
    logic [CONSEC_W-1:0]  r_o_consec;
    logic                 r_o_safe;
    logic                 r_o_rb;

    // store port
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [TIME_W-1:0] w_wdata;
    logic [TIME_W-1:0] w_rdata;

    logic w_rd_go;
    logic w_keep;
    logic w_keep_wr;
    logic w_crash_upd;

    // crash update
    logic [TIME_W:0]     w_since;
    logic                w_restart;
    logic                w_full;
    logic                w_escalate;
    logic [CONSEC_W-1:0] n_consec;
    logic [CW-1:0]       n_count;
    logic [IW-1:0]       n_oldest;
    logic                n_safe;
    logic                n_rb;
    logic [ACTION_W-1:0] n_action;
    logic [KIND_W-1:0]   n_kind;

    // backoff
    logic [CONSEC_W-1:0]  w_sh_raw;
    logic [2:0]           w_shift;
    logic [SHIFTED_W-1:0] w_shifted;
    logic [BACKOFF_W-1:0] w_backoff;

    function automatic logic [IW-1:0] f_adv(input logic [IW-1:0] s);
        return (s == LAST_SLOT) ? '0 : IW'(s + 1'b1);
    endfunction

    clcb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_times (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_slot),
        .o_rdata (w_rdata)
    );

    // prune walk: read one time a cycle, compact kept times toward the oldest
    assign w_rd_go     = i_cmd.scan && (r_rd_idx != r_count);
    assign w_keep      = (({1'b0, w_rdata} + (TIME_W + 1)'(r_window)) >= {1'b0, r_now});
    assign w_keep_wr   = i_cmd.scan && r_pend && w_keep;
    assign w_crash_upd = i_cmd.update && (r_mode == MODE_EXIT) && !r_clean;

    // crash: consecutive count, store and escalation
    always_comb begin
        w_since   = {1'b0, r_now} - {1'b0, r_launch};
        w_restart = (r_launch != '0) && !w_since[TIME_W]
                    && (w_since[TIME_W-1:0] >= TIME_W'(r_window));
        if (w_restart) begin
            n_consec = CONSEC_W'(1);
        end else if (r_consec != CONSEC_MAX) begin
            n_consec = r_consec + 1'b1;
        end else begin
            n_consec = r_consec;
        end

        w_full   = (r_kept == FULL_COUNT);
        n_count  = w_full ? r_kept : CW'(r_kept + 1'b1);
        n_oldest = w_full ? f_adv(r_oldest) : r_oldest;

        w_escalate = (MW'(n_count) >= MW'(r_max_retries));
        n_safe     = r_safe;
        n_rb       = r_rb;
        n_action   = ACT_RESPAWN;
        n_kind     = KIND_PLAIN;
        if (w_escalate) begin
            if (!r_safe) begin
                n_safe = 1'b1;
                n_kind = KIND_SAFE;
            end else if (!r_rb && r_ready) begin
                n_rb   = 1'b1;
                n_kind = KIND_ROLLBACK;
            end else begin
                n_action = ACT_TRIP;
                n_kind   = KIND_TRIP;
            end
        end
    end

    // store write: compaction during the walk, new time at update
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr_slot;
        w_wdata = w_rdata;
        if (w_keep_wr) begin
            w_we = 1'b1;
        end else if (w_crash_upd) begin
            w_we    = 1'b1;
            w_waddr = w_full ? r_oldest : r_wr_slot;
            w_wdata = r_now;
        end
    end

    // backoff: initial doubled per consecutive crash, capped
    always_comb begin
        w_sh_raw  = r_consec - 1'b1;
        w_shift   = (w_sh_raw > CONSEC_W'(BACKOFF_SHIFT_CAP)) ?
                    3'(BACKOFF_SHIFT_CAP) : w_sh_raw[2:0];
        w_shifted = SHIFTED_W'(r_binit) << w_shift;
        if (r_consec == '0) begin
            w_backoff = '0;
        end else if (w_shifted > SHIFTED_W'(r_bmax)) begin
            w_backoff = r_bmax;
        end else begin
            w_backoff = w_shifted[BACKOFF_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= RST_WINDOW;
            r_max_retries <= RST_MAX_RETRIES;
            r_binit       <= RST_BACKOFF_INIT;
            r_bmax        <= RST_BACKOFF_MAX;
            r_count       <= '0;
            r_oldest      <= '0;
            r_consec      <= '0;
            r_safe        <= 1'b0;
            r_rb          <= 1'b0;
            r_launch      <= '0;
            r_action      <= ACT_NONE;
            r_kind        <= KIND_NONE;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW:       r_window      <= i_cfg_data[WINDOW_W-1:0];
                    CFG_MAX_RETRIES:  r_max_retries <= i_cfg_data[RETRY_W-1:0];
                    CFG_BACKOFF_INIT: r_binit       <= i_cfg_data[BACKOFF_W-1:0];
                    CFG_BACKOFF_MAX:  r_bmax        <= i_cfg_data[BACKOFF_W-1:0];
                    default: begin
                    end
                endcase
            end

            // read pipeline flag
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= w_rd_go;
            end

            // event application
            if (i_cmd.update) begin
                r_action <= ACT_NONE;
                r_kind   <= KIND_NONE;
                unique case (r_mode)
                    MODE_LAUNCH: begin
                        r_launch <= r_now;
                    end
                    MODE_EXIT: begin
                        if (r_clean) begin
                            r_consec <= '0;
                            r_action <= ACT_CLEAN;
                        end else begin
                            r_count  <= n_count;
                            r_oldest <= n_oldest;
                            r_consec <= n_consec;
                            r_safe   <= n_safe;
                            r_rb     <= n_rb;
                            r_action <= n_action;
                            r_kind   <= n_kind;
                        end
                    end
                    MODE_CLEAR: begin
                        r_count  <= '0;
                        r_oldest <= '0;
                        r_consec <= '0;
                        r_safe   <= 1'b0;
                        r_rb     <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            // result valid
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: latched item, walk pointers, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_now     <= i_now_sec;
            r_clean   <= i_exit_clean;
            r_ready   <= i_rollback_ready;
            r_rd_idx  <= '0;
            r_rd_slot <= r_oldest;
            r_wr_slot <= r_oldest;
            r_kept    <= '0;
        end else if (i_cmd.scan) begin
            if (w_rd_go) begin
                r_rd_idx  <= CW'(r_rd_idx + 1'b1);
                r_rd_slot <= f_adv(r_rd_slot);
            end
            if (w_keep_wr) begin
                r_wr_slot <= f_adv(r_wr_slot);
                r_kept    <= CW'(r_kept + 1'b1);
            end
        end
        if (i_cmd.emit) begin
            r_o_action  <= r_action;
            r_o_kind    <= r_kind;
            r_o_backoff <= w_backoff;
            r_o_count   <= r_count;
            r_o_consec  <= r_consec;
            r_o_safe    <= r_safe;
            r_o_rb      <= r_rb;
        end
    end

    assign o_sts.in_crash  = (i_mode == MODE_EXIT) && !i_exit_clean;
    assign o_sts.scan_done = (r_rd_idx == r_count) && !r_pend;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid           = r_out_valid;
    assign o_action              = r_o_action;
    assign o_incident_kind       = r_o_kind;
    assign o_backoff_sec         = r_o_backoff;
    assign o_crashes_in_window   = r_o_count;
    assign o_consecutive_crashes = r_o_consec;
    assign o_safe_mode_on        = r_o_safe;
    assign o_rollback_on         = r_o_rb;

endmodule

FILE: hdl/crash_loop_circuit_breaker_core.sv
// ----------------------------------------------------------------------------
// Crash-loop circuit breaker core
// Supervises child launches and exits, prunes crash times outside the window,
// escalates through safe mode, rollback and trip, and reports the backoff.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------------------
//  in       i_in_valid / o_in_stall i_mode, i_now_sec, i_exit_clean,
//                                   i_rollback_ready
//  out      o_out_valid/ i_out_stall o_action, o_incident_kind, o_backoff_sec,
//                                   o_crashes_in_window, o_consecutive_crashes,
//                                   o_safe_mode_on, o_rollback_on
//  cfg      i_cfg_we                i_cfg_idx, i_cfg_data
//
// A crash exit runs the prune walk before the state update and the result,
// reading one of the N stored crash times per cycle.
// Launch, clean exit and clear events skip the walk and go straight to update.
// One item is in work at a time; the result register lets the next item in
// while a result waits. A stalled result holds the block only at hand-off.
// Synchronous active-low reset; the time store needs no clearing.
//
`include "crash_loop_circuit_breaker_core_macros.svh"

module crash_loop_circuit_breaker_core
    import clcb_pkg::*;
#(
    parameter int DEPTH = CLCB_DEPTH,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_now_sec,
    input  logic                  i_exit_clean,
    input  logic                  i_rollback_ready,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ACTION_W-1:0]   o_action,
    output logic [KIND_W-1:0]     o_incident_kind,
    output logic [BACKOFF_W-1:0]  o_backoff_sec,
    output logic [CW-1:0]         o_crashes_in_window,
    output logic [CONSEC_W-1:0]   o_consecutive_crashes,
    output logic                  o_safe_mode_on,
    output logic                  o_rollback_on
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    clcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    clcb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_sts                 (w_sts),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_mode                (i_mode),
        .i_now_sec             (i_now_sec),
        .i_exit_clean          (i_exit_clean),
        .i_rollback_ready      (i_rollback_ready),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_action              (o_action),
        .o_incident_kind       (o_incident_kind),
        .o_backoff_sec         (o_backoff_sec),
        .o_crashes_in_window   (o_crashes_in_window),
        .o_consecutive_crashes (o_consecutive_crashes),
        .o_safe_mode_on        (o_safe_mode_on),
        .o_rollback_on         (o_rollback_on)
    );

    // an accepted item keeps the input side busy on the next cycle
    `CLCB_ASSERT_NEXT(a_busy_after_accept, (i_in_valid && !o_in_stall), o_in_stall, "busy lost")
    // stored crash count never exceeds the store depth
    `CLCB_ASSERT(a_count_bound, (o_out_valid |-> o_crashes_in_window <= DEPTH), "count over depth")
    // a trip only follows safe mode
    `CLCB_ASSERT(a_trip_safe, (o_out_valid && o_action == ACT_TRIP |-> o_safe_mode_on), "trip w/o safe")
    // clean termination clears the streak and raises no incident
    `CLCB_ASSERT(a_clean_exit,
        (o_out_valid && o_action == ACT_CLEAN |->
            o_consecutive_crashes == 8'd0 && o_incident_kind == KIND_NONE),
        "clean exit")

endmodule
